>>> src/pq4cs_pkg.sv
// ----------------------------------------------------------------------------
// pq4cs_pkg
// Shared constants, codes and controller/datapath interface types for the
// 4-bit fast-scan packed code store.
// ----------------------------------------------------------------------------
package pq4cs_pkg;

  // store geometry
  localparam int NUM_BLOCKS        = 8;
  localparam int MAX_SUBQUANTIZERS = 32;
  localparam int MAX_GROUPS_LOG2   = 1;
  localparam int LOG2_GROUP        = 5;                  // 32 vectors per group
  localparam int GROUP_SIZE        = 1 << LOG2_GROUP;
  localparam int HALF_PAIR         = GROUP_SIZE / 2;     // odd sub-quantizer offset
  localparam int MAX_BBS           = GROUP_SIZE << MAX_GROUPS_LOG2;
  localparam int MAX_BYTES_PER_VEC = (MAX_SUBQUANTIZERS + 1) / 2;
  localparam int STORE_DEPTH       = NUM_BLOCKS * MAX_BYTES_PER_VEC * MAX_BBS;

  // field and register widths
  localparam int OP_W     = 1;
  localparam int VEC_W    = 9;
  localparam int BIDX_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int NIB_W    = 4;
  localparam int SQ_W     = 6;
  localparam int GRP_W    = 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = SQ_W;
  localparam int IN_DATA_W  = 24;   // vector_index, byte_index, code_byte, zero fill
  localparam int OUT_DATA_W = 8;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int BLK_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CS_W    = $clog2(MAX_BYTES_PER_VEC + 1);
  localparam int ROW_W   = $clog2(NUM_BLOCKS * MAX_BYTES_PER_VEC);
  localparam int LIM_W   = $clog2(NUM_BLOCKS * MAX_BBS + 1);
  localparam int SHAMT_W = $clog2(LOG2_GROUP + MAX_GROUPS_LOG2 + 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_READ  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUBQUANTIZERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_GROUPS  = 1'b1;

  localparam logic [SQ_W-1:0]  SQ_RESET  = SQ_W'(MAX_SUBQUANTIZERS);
  localparam logic [GRP_W-1:0] GRP_RESET = '0;

  // controller -> datapath
  typedef struct packed {
    logic ld_item;   // latch the accepted beat and its addresses
    logic addr_odd;  // address the odd sub-quantizer byte
    logic mem_we;    // write merged byte back
    logic cap_d0;    // capture read data of the even byte
    logic cap_d1;    // capture read data of the odd byte
    logic ld_out;    // load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_err;    // beat on the input is out of range
    logic is_read;   // latched item is a read
    logic out_free;  // result register can take a new result
  } dp_stat_t;

endpackage

>>> src/pq4cs_ctrl.sv
// ----------------------------------------------------------------------------
// pq4cs_ctrl
// Sequencer for one item: two reads and, for a write, two write-backs on the
// single store port, then hand-off to the result register; errors skip to it.
// ----------------------------------------------------------------------------
module pq4cs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  pq4cs_pkg::dp_stat_t   stat,
  output pq4cs_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD0  = 6'b000010,
    S_RD1  = 6'b000100,
    S_WR0  = 6'b001000,
    S_WR1  = 6'b010000,
    S_PUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = stat.in_err ? S_PUSH : S_RD0;
        end
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.addr_odd = 1'b1;
        cmd.cap_d0   = 1'b1;
        state_nxt    = S_WR0;
      end
      S_WR0: begin
        cmd.cap_d1 = 1'b1;
        cmd.mem_we = !stat.is_read;
        state_nxt  = stat.is_read ? S_PUSH : S_WR1;
      end
      S_WR1: begin
        cmd.addr_odd = 1'b1;
        cmd.mem_we   = 1'b1;
        state_nxt    = S_PUSH;
      end
      S_PUSH: begin
        // hold until the result register frees up
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/pq4cs_datapath.sv
// ----------------------------------------------------------------------------
// pq4cs_datapath
// Configuration registers, range check, fast-scan address generation, the
// packed byte store, nibble merge and the result register.
// ----------------------------------------------------------------------------
module pq4cs_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [pq4cs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pq4cs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [pq4cs_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [pq4cs_pkg::OP_W-1:0]            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pq4cs_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                  out_tuser,
  input  pq4cs_pkg::ctrl_cmd_t                  cmd,
  output pq4cs_pkg::dp_stat_t                   stat
);

  localparam int VEC_W   = pq4cs_pkg::VEC_W;
  localparam int BIDX_W  = pq4cs_pkg::BIDX_W;
  localparam int BYTE_W  = pq4cs_pkg::BYTE_W;
  localparam int NIB_W   = pq4cs_pkg::NIB_W;
  localparam int SQ_W    = pq4cs_pkg::SQ_W;
  localparam int GRP_W   = pq4cs_pkg::GRP_W;
  localparam int ADDR_W  = pq4cs_pkg::ADDR_W;
  localparam int BLK_W   = pq4cs_pkg::BLK_W;
  localparam int CS_W    = pq4cs_pkg::CS_W;
  localparam int ROW_W   = pq4cs_pkg::ROW_W;
  localparam int LIM_W   = pq4cs_pkg::LIM_W;
  localparam int SHAMT_W = pq4cs_pkg::SHAMT_W;
  localparam int LG      = pq4cs_pkg::LOG2_GROUP;

  // configuration
  logic [SQ_W-1:0]  sq_r;
  logic [GRP_W-1:0] grp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r  <= pq4cs_pkg::SQ_RESET;
      grp_r <= pq4cs_pkg::GRP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pq4cs_pkg::CFG_SUBQUANTIZERS: sq_r  <= cfg_wdata[SQ_W-1:0];
        pq4cs_pkg::CFG_BLOCK_GROUPS:  grp_r <= cfg_wdata[GRP_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, saturated
  logic [SQ_W-1:0]    nsq;
  logic [GRP_W-1:0]   grp;
  logic [SQ_W:0]      nsq_p1;
  logic [CS_W-1:0]    bytes_per_vec;
  logic [LIM_W-1:0]   vec_lim;
  logic [SHAMT_W-1:0] shamt;
  logic [VEC_W-1:0]   lane_mask;

  assign nsq = (sq_r > SQ_W'(pq4cs_pkg::MAX_SUBQUANTIZERS)) ?
               SQ_W'(pq4cs_pkg::MAX_SUBQUANTIZERS) : sq_r;
  assign grp = (grp_r > GRP_W'(pq4cs_pkg::MAX_GROUPS_LOG2)) ?
               GRP_W'(pq4cs_pkg::MAX_GROUPS_LOG2) : grp_r;
  assign nsq_p1    = {1'b0, nsq} + (SQ_W+1)'(1);
  assign bytes_per_vec = CS_W'(nsq_p1 >> 1);
  assign shamt     = SHAMT_W'(LG) + SHAMT_W'(grp);
  assign vec_lim   = LIM_W'(pq4cs_pkg::NUM_BLOCKS * pq4cs_pkg::GROUP_SIZE) << grp;
  assign lane_mask = ~(~VEC_W'(0) << shamt);

  // input fields
  logic [VEC_W-1:0]  in_vec;
  logic [BIDX_W-1:0] in_bidx;
  logic [BYTE_W-1:0] in_code;

  assign in_vec  = in_tdata[VEC_W-1:0];
  assign in_bidx = in_tdata[VEC_W +: BIDX_W];
  assign in_code = in_tdata[VEC_W+BIDX_W +: BYTE_W];

  // address of the even nibble byte; the odd one sits HALF_PAIR above
  logic [VEC_W-1:0]  blk_full;
  logic [BLK_W-1:0]  blk;
  logic [VEC_W-1:0]  w;
  logic [VEC_W-1:0]  lane_off;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] addr_even;
  logic              in_err;

  assign blk_full = in_vec >> shamt;
  assign blk      = blk_full[BLK_W-1:0];
  assign w        = in_vec & lane_mask;
  // lanes 0..7 go to even bytes, lanes 8..15 to odd bytes
  assign lane_off = {w[VEC_W-1:LG], 1'b0, w[2:0], w[3]};
  assign row      = (ROW_W'(blk) * ROW_W'(bytes_per_vec)) + ROW_W'(in_bidx);
  assign addr_even = (ADDR_W'(row) << shamt) + ADDR_W'(lane_off);
  assign in_err   = ({1'b0, in_vec} >= LIM_W'(vec_lim)) ||
                    ({1'b0, in_bidx} >= (BIDX_W+1)'(bytes_per_vec));

  // latched item
  logic [ADDR_W-1:0] addr_r;
  logic              high_r;
  logic              err_r;
  logic              rd_r;
  logic [BYTE_W-1:0] code_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      addr_r <= addr_even;
      high_r <= w[LG-1];
      err_r  <= in_err;
      rd_r   <= (in_tuser == pq4cs_pkg::OP_READ);
      code_r <= in_code;
    end
  end

  // store: one port, registered read
  logic [BYTE_W-1:0] mem [pq4cs_pkg::STORE_DEPTH];
  logic [ADDR_W-1:0] mem_addr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] rdata_r;
  logic [BYTE_W-1:0] d0_r;
  logic [BYTE_W-1:0] d1_r;
  logic [BYTE_W-1:0] old_byte;
  logic [NIB_W-1:0]  new_nib;

  assign mem_addr = cmd.addr_odd ? (addr_r | ADDR_W'(pq4cs_pkg::HALF_PAIR)) : addr_r;
  assign old_byte = cmd.addr_odd ? d1_r : d0_r;
  assign new_nib  = cmd.addr_odd ? code_r[BYTE_W-1:NIB_W] : code_r[NIB_W-1:0];
  assign mem_wdata = high_r ? {new_nib, old_byte[NIB_W-1:0]} :
                              {old_byte[BYTE_W-1:NIB_W], new_nib};

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  // even byte data arrives ahead of the odd one
  always_ff @(posedge clk) begin
    if (cmd.cap_d0) begin
      d0_r <= rdata_r;
    end
    if (cmd.cap_d1) begin
      d1_r <= rdata_r;
    end
  end

  // gather both nibbles back into one byte for a read
  logic [NIB_W-1:0]  nib0;
  logic [NIB_W-1:0]  nib1;
  logic [BYTE_W-1:0] result;

  assign nib0   = high_r ? d0_r[BYTE_W-1:NIB_W] : d0_r[NIB_W-1:0];
  assign nib1   = high_r ? d1_r[BYTE_W-1:NIB_W] : d1_r[NIB_W-1:0];
  assign result = (rd_r && !err_r) ? {nib1, nib0} : '0;

  // result register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_byte_r <= result;
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_err_r;

  assign stat.in_err   = in_err;
  assign stat.is_read  = rd_r;
  assign stat.out_free = !out_valid_r || out_tready;

endmodule

>>> src/pq4_packed_code_store.sv
// ----------------------------------------------------------------------------
// pq4_packed_code_store
// Byte store of 4-bit product-quantizer codes in fast-scan block layout.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one flat code byte access: in_tuser selects write (0)
//   or read (1); in_tdata holds vector_index, byte_index and code_byte.
//   A write splits the byte into its two nibbles and places each one by
//   read-modify-write at its interleaved block/pair/lane/half position.
//   A read gathers both nibbles back into a byte.
//   Every beat gives exactly one result beat: out_tdata is the read byte
//   (zero for writes and errors), out_tuser flags an out-of-range index.
//   Items pass one at a time through the single store port: a write
//   takes two reads, two write-backs and the result hand-off, a read
//   skips the write-backs and an out-of-range item needs only the
//   hand-off. The result beat is valid the cycle after the hand-off. The
//   result register decouples the sides: the next beat is accepted while
//   the previous result still waits; a stalled receiver holds the
//   sequencer only at hand-off of the following result. Reset clears the
//   sequencer, the result valid and the configuration (subquantizers 32,
//   block_groups_log2 0). Store contents are not cleared; the user, not
//   the block, must ensure bytes are read only after they were written.
//   Write the configuration only while no item is in flight.
// ----------------------------------------------------------------------------
module pq4_packed_code_store (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration write port
  input  logic                                  cfg_wr_en,
  input  logic [pq4cs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pq4cs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pq4cs_pkg::IN_DATA_W-1:0]       in_tdata,  // vector_index[8:0], byte_index[12:9],
                                                           // code_byte[20:13], zero[23:21]
  input  logic [pq4cs_pkg::OP_W-1:0]            in_tuser,  // op[0]
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pq4cs_pkg::OUT_DATA_W-1:0]      out_tdata, // read_byte[7:0]
  output logic                                  out_tuser  // range_error[0]
);

  pq4cs_pkg::ctrl_cmd_t cmd;
  pq4cs_pkg::dp_stat_t  stat;

  pq4cs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pq4cs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

>>> src/pq4cs_checker.sv
// ----------------------------------------------------------------------------
// pq4cs_checker
// Port-level checks for the packed code store, bound to the top level.
// ----------------------------------------------------------------------------
module pq4cs_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [pq4cs_pkg::OUT_DATA_W-1:0]      out_tdata,
  input logic                                  out_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // flagged items carry a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("range error with nonzero byte");

  // one item at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted back-to-back beats");

  // reset drops any pending result
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind pq4_packed_code_store pq4cs_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> verif/pq4_packed_code_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pq4_packed_code_store_tb
// Self-checking bench for the 4-bit fast-scan packed code store. A directed
// table under the reset setting, then random write/read beats under several
// register settings, with random idling on both streams and one long
// receiver hold-off. Every result beat is compared against the table's
// expected result or a local model of the interleaved store layout.
// ----------------------------------------------------------------------------
module pq4_packed_code_store_tb;
  import pq4cs_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 50;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [VEC_W-1:0]  vec;
    logic [BIDX_W-1:0] bidx;
    logic [BYTE_W-1:0] code;
  } code_access_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rbyte;
    logic              err;
  } code_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [VEC_W-1:0]  vec;
    logic [BIDX_W-1:0] bidx;
    logic [BYTE_W-1:0] code;
    logic              typed;
    logic [BYTE_W-1:0] exp_byte;
    logic              exp_err;
  } dir_row_t;

  typedef struct packed {
    logic [VEC_W-1:0]  vec;
    logic [BIDX_W-1:0] bidx;
  } code_slot_t;

  // directed beats under the reset setting (32 sub-quantizers, 32-vector blocks)
  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_WRITE, 9'd0,   4'd0,  8'hA5, 1'b1, 8'h00, 1'b0},
    '{OP_READ,  9'd0,   4'd0,  8'h00, 1'b1, 8'hA5, 1'b0},
    '{OP_WRITE, 9'd255, 4'd15, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{OP_READ,  9'd255, 4'd15, 8'h00, 1'b1, 8'hFF, 1'b0},
    '{OP_WRITE, 9'd255, 4'd15, 8'h00, 1'b1, 8'h00, 1'b0},
    '{OP_READ,  9'd255, 4'd15, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{OP_WRITE, 9'd256, 4'd0,  8'h5A, 1'b1, 8'h00, 1'b1},
    '{OP_READ,  9'd511, 4'd15, 8'hFF, 1'b1, 8'h00, 1'b1},
    // lanes 0 and 16 share a store byte, low and high half
    '{OP_WRITE, 9'd16,  4'd3,  8'h3C, 1'b1, 8'h00, 1'b0},
    '{OP_WRITE, 9'd0,   4'd3,  8'hC3, 1'b1, 8'h00, 1'b0},
    '{OP_READ,  9'd16,  4'd3,  8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_READ,  9'd0,   4'd3,  8'h00, 1'b0, 8'h00, 1'b0},
    // lanes 8..15 land on the odd byte positions
    '{OP_WRITE, 9'd8,   4'd1,  8'h81, 1'b1, 8'h00, 1'b0},
    '{OP_WRITE, 9'd24,  4'd1,  8'h18, 1'b1, 8'h00, 1'b0},
    '{OP_READ,  9'd8,   4'd1,  8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_READ,  9'd24,  4'd1,  8'h00, 1'b0, 8'h00, 1'b0},
    // last lane of block 0 against first lane of block 1
    '{OP_WRITE, 9'd31,  4'd8,  8'h96, 1'b1, 8'h00, 1'b0},
    '{OP_WRITE, 9'd32,  4'd8,  8'h69, 1'b1, 8'h00, 1'b0},
    '{OP_READ,  9'd31,  4'd8,  8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_READ,  9'd32,  4'd8,  8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_WRITE, 9'd170, 4'd10, 8'h55, 1'b1, 8'h00, 1'b0},
    '{OP_READ,  9'd170, 4'd10, 8'hAA, 1'b1, 8'h55, 1'b0}
  };

  // phase 0 keeps the reset setting; the others are written before they start
  localparam logic [SQ_W-1:0] PHASE_SQ [PHASES] =
    '{6'd32, 6'd7, 6'd0, 6'd1, 6'd63, 6'd16, 6'd32, 6'd40};
  localparam logic [GRP_W-1:0] PHASE_GRP [PHASES] =
    '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SUBQUANTIZERS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;  // vector_index[8:0], byte_index[12:9], code_byte[20:13]
  logic [OP_W-1:0]       in_tuser = OP_WRITE;  // op[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // read_byte[7:0]
  logic                  out_tuser;  // range_error[0]

  // mirror of the packed store, one entry per nibble half
  logic [NIB_W-1:0] nib_mirror [STORE_DEPTH][2];
  bit               nib_written [STORE_DEPTH][2];
  logic [SQ_W-1:0]  model_sq = SQ_RESET;
  logic [GRP_W-1:0] model_grp = GRP_RESET;

  code_result_t owed_results [$];
  code_slot_t   phase_slots [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int hold_left = 0;
  int fail_cnt = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_reads = 0;
  int n_flagged = 0;
  int n_settings = 1;

  pq4_packed_code_store DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // vectors per block and bytes per code under the current setting
  function automatic void layout_geometry(output int unsigned bbs, output int unsigned csz);
    int unsigned nsq;
    nsq = (model_sq > MAX_SUBQUANTIZERS) ? MAX_SUBQUANTIZERS : model_sq;
    bbs = GROUP_SIZE << model_grp;
    csz = (nsq + 1) / 2;
  endfunction

  function automatic int unsigned nibble_loc(input int unsigned v, input int unsigned sq,
                                             input int unsigned bbs, input int unsigned csz,
                                             output bit hi);
    int unsigned w, l, pos;
    w   = v % bbs;
    l   = w % HALF_PAIR;
    pos = (l < 8) ? 2 * l : 2 * (l - 8) + 1;
    hi  = (w % GROUP_SIZE) >= HALF_PAIR;
    if (sq % 2 == 1) pos += HALF_PAIR;
    return ((v / bbs) * csz * bbs + (sq / 2) * bbs + (w / GROUP_SIZE) * GROUP_SIZE + pos)
           % STORE_DEPTH;
  endfunction

  function automatic bit slot_in_range(input int unsigned v, input int unsigned bi);
    int unsigned bbs, csz;
    layout_geometry(bbs, csz);
    return (v < NUM_BLOCKS * bbs) && (bi < csz);
  endfunction

  // both nibbles of the slot hold written data
  function automatic bit slot_readable(input int unsigned v, input int unsigned bi);
    int unsigned bbs, csz, a0, a1;
    bit h0, h1;
    layout_geometry(bbs, csz);
    a0 = nibble_loc(v, 2 * bi, bbs, csz, h0);
    a1 = nibble_loc(v, 2 * bi + 1, bbs, csz, h1);
    return nib_written[a0][h0] && nib_written[a1][h1];
  endfunction

  // apply one accepted beat to the mirror and return the result it owes
  function automatic code_result_t model_code_access(input code_access_t acc);
    int unsigned bbs, csz, a0, a1;
    bit h0, h1;
    code_result_t r;
    r = '0;
    layout_geometry(bbs, csz);
    if (!slot_in_range(acc.vec, acc.bidx)) begin
      r.err = 1'b1;
      n_flagged++;
      return r;
    end
    a0 = nibble_loc(acc.vec, 2 * acc.bidx, bbs, csz, h0);
    a1 = nibble_loc(acc.vec, 2 * acc.bidx + 1, bbs, csz, h1);
    if (acc.op == OP_WRITE) begin
      nib_mirror[a0][h0]  = acc.code[3:0];
      nib_mirror[a1][h1]  = acc.code[7:4];
      nib_written[a0][h0] = 1'b1;
      nib_written[a1][h1] = 1'b1;
      n_writes++;
    end else begin
      r.rbyte = {nib_mirror[a1][h1], nib_mirror[a0][h0]};
      n_reads++;
    end
    return r;
  endfunction

  // mostly in-range slots; reads favor slots written in this phase
  function automatic code_access_t next_access();
    int unsigned bbs, csz;
    code_access_t acc;
    code_slot_t   pick;
    layout_geometry(bbs, csz);
    acc.code = BYTE_W'($urandom_range(255));
    acc.op   = $urandom_range(1) ? OP_READ : OP_WRITE;
    if (acc.op == OP_READ && phase_slots.size() > 0 && $urandom_range(99) < 75) begin
      pick     = phase_slots[$urandom_range(phase_slots.size() - 1)];
      acc.vec  = pick.vec;
      acc.bidx = pick.bidx;
    end else begin
      acc.vec  = VEC_W'(($urandom_range(9) != 0) ? $urandom_range(NUM_BLOCKS * bbs - 1)
                                                 : $urandom_range(511));
      acc.bidx = BIDX_W'((csz > 0 && $urandom_range(9) != 0) ? $urandom_range(csz - 1)
                                                             : $urandom_range(15));
      // never read a nibble that holds no written data
      if (acc.op == OP_READ && slot_in_range(acc.vec, acc.bidx) &&
          !slot_readable(acc.vec, acc.bidx))
        acc.op = OP_WRITE;
    end
    return acc;
  endfunction

  task automatic send_access(input code_access_t acc, input bit typed, input code_result_t fixed);
    code_result_t pred;
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, acc.code, acc.bidx, acc.vec};
    in_tuser  <= acc.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = model_code_access(acc);
    owed_results.push_back(typed ? fixed : pred);
    if (acc.op == OP_WRITE && !pred.err) phase_slots.push_back('{acc.vec, acc.bidx});
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic write_settings(input logic [SQ_W-1:0] sq, input logic [GRP_W-1:0] grp);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SUBQUANTIZERS;
    cfg_wdata <= sq;
    @(posedge clk);
    cfg_index <= CFG_BLOCK_GROUPS;
    cfg_wdata <= CFG_DATA_W'(grp);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_sq  = sq;
    model_grp = grp;
    n_settings++;
  endtask

  // receiver: random ready, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    code_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_results.size() == 0) begin
        $display("%0t ERROR result beat with none pending: read_byte %02h range_error %0b",
                 $time, out_tdata, out_tuser);
        fail_cnt++;
      end else begin
        want = owed_results.pop_front();
        if (out_tdata !== want.rbyte) begin
          $display("%0t ERROR read_byte expected %02h actual %02h", $time, want.rbyte, out_tdata);
          fail_cnt++;
        end
        if (out_tuser !== want.err) begin
          $display("%0t ERROR range_error expected %0b actual %0b", $time, want.err, out_tuser);
          fail_cnt++;
        end
        n_checked++;
      end
    end
  end

  initial begin
    int ph;
    int i;
    dir_row_t row;
    code_access_t acc;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        // drain, then reprogram while the block is idle
        in_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        write_settings(PHASE_SQ[ph], PHASE_GRP[ph]);
      end
      tx_idle_pct = (ph < 3) ? 15 : (ph < 6) ? 79 : 0;
      rx_idle_pct = (ph < 3) ? 79 : (ph < 6) ? 15 : 0;
      if (ph == 6) stall_req <= stall_req + 1;
      phase_slots.delete();
      if (ph == 0) begin
        for (i = 0; i < DIR_ROWS; i++) begin
          row = DIRECTED[i];
          acc = '{row.op, row.vec, row.bidx, row.code};
          send_access(acc, row.typed, '{row.exp_byte, row.exp_err});
        end
      end
      repeat (PHASE_ITEMS) send_access(next_access(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d writes, %0d reads and %0d out-of-range beats over %0d settings",
             n_writes, n_reads, n_flagged, n_settings);
    $display("%0d result beats checked, %0d mismatches", n_checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/pq4cs_pkg.sv
src/pq4cs_ctrl.sv
src/pq4cs_datapath.sv
src/pq4_packed_code_store.sv
src/pq4cs_checker.sv
verif/pq4_packed_code_store_tb.sv
